@@ rtl/core/bxavg_pkg.sv @@
`timescale 1ns / 1ps
// bxavg_pkg: shared types and constants for the box-average downscaler.
// No dependencies; imported by box_average_downsample_core and bxavg_div.
package bxavg_pkg;

  // Configuration register widths and codes
  localparam int FACT_W     = 5;
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [FACT_W-1:0] RST_FACTOR = FACT_W'(1);
  localparam logic [WID_W-1:0]  RST_WIDTH  = WID_W'(1024);
  localparam logic [HGT_W-1:0]  RST_HEIGHT = HGT_W'(4096);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FACTOR = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_reg_e;

  // Frame geometry limits
  localparam int MAX_HEIGHT     = 4096;
  localparam int ROW_W          = $clog2(MAX_HEIGHT);
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_FACTOR = 16;

  // Datapath widths: pixel, row-segment sum, block sum, factor squared.
  // The block sum leaves headroom for offsets left out of step by a
  // mid-frame factor change (up to 31 row segments of 31 pixels).
  localparam int PIX_W = 8;
  localparam int HP_W  = 13;
  localparam int SUM_W = 18;
  localparam int FF_W  = 10;
  localparam int DCNT_W = $clog2(SUM_W + 1);

  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ACC,
    ST_DIVW,
    ST_DIV
  } state_e;

  // Divisions run after reset or a configuration write
  typedef enum logic [1:0] {
    INIT_COLS,
    INIT_ROWS,
    INIT_CPOS,
    INIT_RPOS
  } init_step_e;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [FF_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quot;
    logic [FF_W-1:0]  rem;
  } div_rsp_t;

endpackage

@@ rtl/core/box_average_downsample_core.sv @@
`timescale 1ns / 1ps
// Box-average downscaler: each output is the truncated mean of a factor-by-factor block.
// Flow: a pixel inside a block row segment needs no extra state; the last pixel of a block
// segment adds ST_ACC (read-modify-write of the column-sum RAM); a block-completing pixel then
// waits in ST_DIVW for a free output register and runs the shared 18-step divider (ST_DIV)
// before the next pixel. Reset (async, active low) and every configuration write start a setup
// (four divisions) during which no pixel is taken. Depends on bxavg_pkg, bxavg_ram, bxavg_div.
module box_average_downsample_core import bxavg_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      pixel_value_i,
  // result output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      mean_value_o,
  output logic                  row_end_o,
  output logic                  frame_end_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  // Configuration registers and clamped values
  logic [FACT_W-1:0] fac_q;
  logic [WID_W-1:0]  wid_q;
  logic [HGT_W-1:0]  hgt_q;
  logic [FACT_W-1:0] f;
  logic [WID_W-1:0]  w;
  logic [HGT_W-1:0]  h;
  logic [FF_W-1:0]   ff_q;

  // Geometry derived at setup
  logic [WID_W-1:0] out_cols_q, out_cols_d;
  logic [HGT_W-1:0] out_rows_q, out_rows_d;

  // Raster position and block tracking
  logic [CW-1:0]     col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [FACT_W-1:0] offc_q, offc_d;
  logic [FACT_W-1:0] offr_q, offr_d;
  logic [HP_W-1:0]   hp_q, hp_d;
  logic [CW-1:0]     oc_q, oc_d;
  logic [FACT_W-1:0] crem_q, crem_d;
  logic [ROW_W-1:0]  orow_q, orow_d;
  logic [FACT_W-1:0] rrem_q, rrem_d;

  // Sequencer
  state_e     state_q, state_d;
  init_step_e init_idx_q, init_idx_d;
  logic       init_run_q, init_run_d;
  logic       reinit_q, reinit_d;

  // Pending block-segment update
  logic [CW-1:0]    pend_addr_q, pend_addr_d;
  logic             pend_first_q, pend_first_d;
  logic             pend_emit_q, pend_emit_d;
  logic             pend_rend_q, pend_rend_d;
  logic             pend_fend_q, pend_fend_d;
  logic [HP_W-1:0]  pend_hp_q, pend_hp_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [SUM_W-1:0] sum_new;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic [PIX_W-1:0] mean_q, mean_d;
  logic             rend_q, rend_d;
  logic             fend_q, fend_d;

  // RAM and divider hookup
  logic             ram_re, ram_we;
  logic [SUM_W-1:0] ram_rdata;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // Per-pixel combinational terms
  logic              accept;
  logic              in_area;
  logic              blkend;
  logic [HP_W-1:0]   hp_new;
  logic [CW:0]       col_inc;
  logic [ROW_W:0]    row_inc;
  logic [FACT_W:0]   offc_inc, offr_inc, crem_inc, rrem_inc;

  // Clamp configuration into the legal range
  always_comb begin
    if (fac_q == '0) begin
      f = FACT_W'(1);
    end else if (32'(fac_q) > MAX_FACTOR) begin
      f = FACT_W'(MAX_FACTOR);
    end else begin
      f = fac_q;
    end
    if (wid_q == '0) begin
      w = WID_W'(1);
    end else if (32'(wid_q) > MAX_WIDTH) begin
      w = WID_W'(MAX_WIDTH);
    end else begin
      w = wid_q;
    end
    if (hgt_q == '0) begin
      h = HGT_W'(1);
    end else if (32'(hgt_q) > MAX_HEIGHT) begin
      h = HGT_W'(MAX_HEIGHT);
    end else begin
      h = hgt_q;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fac_q <= RST_FACTOR;
      wid_q <= RST_WIDTH;
      hgt_q <= RST_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FACTOR: fac_q <= cfg_data_i[FACT_W-1:0];
        CFG_WIDTH:  wid_q <= cfg_data_i[WID_W-1:0];
        CFG_HEIGHT: hgt_q <= cfg_data_i[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  // Divisor for the block mean
  always_ff @(posedge clk_i) begin
    ff_q <= FF_W'(f) * FF_W'(f);
  end

  // Pixel classification and counter increments
  assign in_ready_o = (state_q == ST_IDLE) && !reinit_q && !cfg_we_i;
  assign accept     = in_valid_i && in_ready_o;

  assign in_area  = (32'(oc_q) < 32'(out_cols_q)) && (32'(orow_q) < 32'(out_rows_q));
  assign offc_inc = {1'b0, offc_q} + 1'b1;
  assign offr_inc = {1'b0, offr_q} + 1'b1;
  assign crem_inc = {1'b0, crem_q} + 1'b1;
  assign rrem_inc = {1'b0, rrem_q} + 1'b1;
  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign row_inc  = {1'b0, row_q} + 1'b1;
  assign blkend   = in_area && (offc_inc == {1'b0, f});
  assign hp_new   = (offc_q == '0) ? HP_W'(pixel_value_i) : hp_q + HP_W'(pixel_value_i);

  // Read-modify-write of the column sum
  assign sum_new = pend_first_q ? SUM_W'(pend_hp_q) : ram_rdata + SUM_W'(pend_hp_q);

  // Sequencer: setup divisions, pixel intake, RAM update, mean division
  always_comb begin
    state_d      = state_q;
    init_idx_d   = init_idx_q;
    init_run_d   = init_run_q;
    reinit_d     = reinit_q || cfg_we_i;
    out_cols_d   = out_cols_q;
    out_rows_d   = out_rows_q;
    col_d        = col_q;
    row_d        = row_q;
    offc_d       = offc_q;
    offr_d       = offr_q;
    hp_d         = hp_q;
    oc_d         = oc_q;
    crem_d       = crem_q;
    orow_d       = orow_q;
    rrem_d       = rrem_q;
    pend_addr_d  = pend_addr_q;
    pend_first_d = pend_first_q;
    pend_emit_d  = pend_emit_q;
    pend_rend_d  = pend_rend_q;
    pend_fend_d  = pend_fend_q;
    pend_hp_d    = pend_hp_q;
    sum_d        = sum_q;
    mean_d       = mean_q;
    rend_d       = rend_q;
    fend_d       = fend_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    ram_re       = 1'b0;
    ram_we       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = sum_q;
    div_req.divisor  = ff_q;

    case (state_q)
      ST_INIT: begin
        reinit_d = 1'b0;
        if (cfg_we_i) begin
          init_idx_d = INIT_COLS;
          init_run_d = 1'b0;
        end else if (!init_run_q) begin
          div_req.start   = 1'b1;
          div_req.divisor = FF_W'(f);
          case (init_idx_q)
            INIT_COLS: div_req.dividend = SUM_W'(w);
            INIT_ROWS: div_req.dividend = SUM_W'(h);
            INIT_CPOS: div_req.dividend = SUM_W'(col_q);
            INIT_RPOS: div_req.dividend = SUM_W'(row_q);
            default:   div_req.dividend = '0;
          endcase
          init_run_d = 1'b1;
        end else if (div_rsp.done) begin
          init_run_d = 1'b0;
          case (init_idx_q)
            INIT_COLS: out_cols_d = WID_W'(div_rsp.quot);
            INIT_ROWS: out_rows_d = HGT_W'(div_rsp.quot);
            INIT_CPOS: begin
              oc_d   = CW'(div_rsp.quot);
              crem_d = FACT_W'(div_rsp.rem);
            end
            INIT_RPOS: begin
              orow_d = ROW_W'(div_rsp.quot);
              rrem_d = FACT_W'(div_rsp.rem);
            end
            default: ;
          endcase
          if (init_idx_q == INIT_RPOS) begin
            state_d = ST_IDLE;
          end else begin
            init_idx_d = init_step_e'(init_idx_q + 2'd1);
          end
        end
      end

      ST_IDLE: begin
        if (cfg_we_i || reinit_q) begin
          state_d    = ST_INIT;
          init_idx_d = INIT_COLS;
          init_run_d = 1'b0;
          reinit_d   = 1'b0;
        end else if (accept) begin
          // row segment of the current block
          if (in_area) begin
            hp_d = hp_new;
          end
          // last pixel of a block row segment: update its column sum
          if (blkend) begin
            ram_re       = 1'b1;
            pend_addr_d  = oc_q;
            pend_first_d = (offr_q == '0);
            pend_emit_d  = (offr_inc == {1'b0, f});
            pend_rend_d  = (32'(oc_q) + 32'd1 == 32'(out_cols_q));
            pend_fend_d  = (32'(oc_q) + 32'd1 == 32'(out_cols_q)) &&
                           (32'(orow_q) + 32'd1 == 32'(out_rows_q));
            pend_hp_d    = hp_new;
            state_d      = ST_ACC;
          end
          // advance the raster position
          col_d  = CW'(col_inc);
          offc_d = (offc_inc >= {1'b0, f}) ? '0 : FACT_W'(offc_inc);
          if (crem_inc == {1'b0, f}) begin
            crem_d = '0;
            oc_d   = oc_q + 1'b1;
          end else begin
            crem_d = FACT_W'(crem_inc);
          end
          if (32'(col_inc) >= 32'(w)) begin
            col_d  = '0;
            offc_d = '0;
            hp_d   = '0;
            crem_d = '0;
            oc_d   = '0;
            row_d  = ROW_W'(row_inc);
            offr_d = (offr_inc >= {1'b0, f}) ? '0 : FACT_W'(offr_inc);
            if (rrem_inc == {1'b0, f}) begin
              rrem_d = '0;
              orow_d = orow_q + 1'b1;
            end else begin
              rrem_d = FACT_W'(rrem_inc);
            end
            if (32'(row_inc) >= 32'(h)) begin
              row_d  = '0;
              offr_d = '0;
              rrem_d = '0;
              orow_d = '0;
            end
          end
        end
      end

      ST_ACC: begin
        ram_we = 1'b1;
        sum_d  = sum_new;
        state_d = pend_emit_q ? ST_DIVW : ST_IDLE;
      end

      ST_DIVW: begin
        if (!out_valid_q) begin
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          mean_d      = (div_rsp.quot > SUM_W'(PIX_MAX)) ? PIX_MAX : div_rsp.quot[PIX_W-1:0];
          rend_d      = pend_rend_q;
          fend_d      = pend_fend_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  // Control and position state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_idx_q  <= INIT_COLS;
      init_run_q  <= 1'b0;
      reinit_q    <= 1'b0;
      out_cols_q  <= '0;
      out_rows_q  <= '0;
      col_q       <= '0;
      row_q       <= '0;
      offc_q      <= '0;
      offr_q      <= '0;
      hp_q        <= '0;
      oc_q        <= '0;
      crem_q      <= '0;
      orow_q      <= '0;
      rrem_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_idx_q  <= init_idx_d;
      init_run_q  <= init_run_d;
      reinit_q    <= reinit_d;
      out_cols_q  <= out_cols_d;
      out_rows_q  <= out_rows_d;
      col_q       <= col_d;
      row_q       <= row_d;
      offc_q      <= offc_d;
      offr_q      <= offr_d;
      hp_q        <= hp_d;
      oc_q        <= oc_d;
      crem_q      <= crem_d;
      orow_q      <= orow_d;
      rrem_q      <= rrem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_addr_q  <= pend_addr_d;
    pend_first_q <= pend_first_d;
    pend_emit_q  <= pend_emit_d;
    pend_rend_q  <= pend_rend_d;
    pend_fend_q  <= pend_fend_d;
    pend_hp_q    <= pend_hp_d;
    sum_q        <= sum_d;
    mean_q       <= mean_d;
    rend_q       <= rend_d;
    fend_q       <= fend_d;
  end

  // Column block sums, one entry per output column
  bxavg_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_WIDTH)
  ) u_colsum_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pend_addr_q),
    .wdata_i(sum_new),
    .re_i   (ram_re),
    .raddr_i(oc_q),
    .rdata_o(ram_rdata)
  );

  // Shared divider: setup geometry and block means
  bxavg_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign out_valid_o  = out_valid_q;
  assign mean_value_o = mean_q;
  assign row_end_o    = rend_q;
  assign frame_end_o  = fend_q;

endmodule

@@ rtl/core/bxavg_ram.sv @@
`timescale 1ns / 1ps
// bxavg_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module bxavg_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/bxavg_div.sv @@
`timescale 1ns / 1ps
// bxavg_div: restoring divider, one quotient bit per cycle.
// Depends on bxavg_pkg (widths, request/response structs).
module bxavg_div import bxavg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [FF_W-1:0]   rem_q, rem_d;
  logic [FF_W-1:0]   dvs_q, dvs_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [FF_W:0]     shifted;
  logic [FF_W:0]     diff;

  // Trial subtraction of one step
  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      // a new start aborts any division in flight
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = DCNT_W'(SUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[FF_W]) begin
        rem_d = diff[FF_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[FF_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ rtl/core/bxavg_checker.sv @@
`timescale 1ns / 1ps
// bxavg_checker: port-level assertions for box_average_downsample_core.
// No package dependency; attached to the top level by the bind below.
module bxavg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] mean_value_o,
  input logic       row_end_o,
  input logic       frame_end_o
);

  // A waiting result keeps its value until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mean_value_o) &&
    $stable(row_end_o) && $stable(frame_end_o))
    else $error("output transaction changed while stalled");

  // The last output of a frame also closes its output row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !frame_end_o || row_end_o)
    else $error("frame_end without row_end");

  // Setup after reset: no pixel taken when reset is released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("pixel accepted before setup");

  // A configuration write forces a new setup before the next pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o)
    else $error("pixel accepted right after configuration write");

  // A result is never produced in the cycle right after a pixel transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !(out_valid_o && !$past(out_valid_o)))
    else $error("result appeared too early after pixel");

endmodule

bind box_average_downsample_core bxavg_checker u_bxavg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .mean_value_o(mean_value_o),
  .row_end_o   (row_end_o),
  .frame_end_o (frame_end_o)
);
